>>> hw/rtl/vertical_capsule_contact_defines.svh
// assertion macros for the capsule contact block
`ifndef VERTICAL_CAPSULE_CONTACT_DEFINES_SVH
`define VERTICAL_CAPSULE_CONTACT_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define VCC_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("vcc check failed");

// next-cycle implication, disabled while in reset
`define VCC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("vcc check failed");

`endif

>>> hw/rtl/vcc_pkg.sv
`default_nettype none
package vcc_pkg;

    localparam int unsigned SQ_STEPS   = 25;  // root bits of a 50 bit square
    localparam int unsigned DIV_STEPS  = 17;  // quotient bits, up to 1.0 in q16.16
    localparam int unsigned FRONT_LAT  = 4;
    localparam int unsigned PAY_DEPTH  = SQ_STEPS + DIV_STEPS;
    localparam int unsigned TOTAL_LAT  = FRONT_LAT + PAY_DEPTH + 2;
    localparam logic [16:0] ONE_Q16    = 17'h10000;

    typedef struct packed {
        logic signed [31:0] ax;
        logic signed [31:0] az;
        logic signed [31:0] bx;
        logic signed [31:0] bz;
        logic [23:0]        ra;
        logic [23:0]        rb;
        logic               cy_ge;
    } base_t;

    typedef struct packed {
        base_t              base;
        logic [24:0]        rs;
        logic signed [31:0] ya;
        logic signed [31:0] yb;
        logic [24:0]        mdx;
        logic [24:0]        mdz;
        logic [24:0]        vert;
        logic               dx_neg;
        logic               dz_neg;
        logic               dy_neg;
        logic               miss;
        logic               zero;
        logic [49:0]        dist_sq;
    } front_t;

    function automatic logic signed [32:0] sx33(input logic signed [31:0] v);
        return {v[31], v};
    endfunction

endpackage
`default_nettype wire

>>> hw/rtl/vertical_capsule_contact.sv
// channel | direction | handshake          | payload
// s_      | in        | s_valid / s_ready  | two capsules, a_* and b_*
// m_      | out       | m_valid / m_ready  | hit, normal, penetration, point
//
// one item per cycle sustained while the output item is not held (m_valid high, m_ready low)
// stages: 4 front stages, 25 square root stages, 17 divide stages, product, output
// aresetn (synchronous, active low) clears only the valid line
// a stall at m_ready freezes every stage at once; s_ready follows the output register
// and stays low in reset
`default_nettype none
module vertical_capsule_contact import vcc_pkg::*; (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic signed [31:0] s_a_x,
    input  wire logic signed [31:0] s_a_z,
    input  wire logic signed [31:0] s_a_y0,
    input  wire logic signed [31:0] s_a_y1,
    input  wire logic [23:0]        s_a_radius,
    input  wire logic signed [31:0] s_a_center_y,
    input  wire logic signed [31:0] s_b_x,
    input  wire logic signed [31:0] s_b_z,
    input  wire logic signed [31:0] s_b_y0,
    input  wire logic signed [31:0] s_b_y1,
    input  wire logic [23:0]        s_b_radius,
    input  wire logic signed [31:0] s_b_center_y,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic                    m_hit,
    output logic signed [17:0]      m_normal_x,
    output logic signed [17:0]      m_normal_y,
    output logic signed [17:0]      m_normal_z,
    output logic [24:0]             m_penetration,
    output logic signed [31:0]      m_point_x,
    output logic signed [31:0]      m_point_y,
    output logic signed [31:0]      m_point_z
);

    // global advance: the whole pipe moves unless the output item is held
    logic                 en;
    logic [TOTAL_LAT-1:0] vld_reg;

    assign en      = !vld_reg[TOTAL_LAT-1] || m_ready;
    assign s_ready = en && aresetn;
    assign m_valid = vld_reg[TOTAL_LAT-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[TOTAL_LAT-2:0], s_valid};
        end
    end

    // front: ordering, gap, squares, miss test
    front_t fr;

    vcc_front u_front (
        .aclk       (aclk),
        .en         (en),
        .a_x        (s_a_x),
        .a_z        (s_a_z),
        .a_y0       (s_a_y0),
        .a_y1       (s_a_y1),
        .a_radius   (s_a_radius),
        .a_center_y (s_a_center_y),
        .b_x        (s_b_x),
        .b_z        (s_b_z),
        .b_y0       (s_b_y0),
        .b_y1       (s_b_y1),
        .b_radius   (s_b_radius),
        .b_center_y (s_b_center_y),
        .fr         (fr)
    );

    // distance: floor square root of the squared distance
    logic [24:0] root_q;

    vcc_sqrt u_sqrt (
        .aclk  (aclk),
        .en    (en),
        .value (fr.dist_sq),
        .root  (root_q)
    );

    // item fields ride alongside the root and divide stages
    front_t      pay_reg  [PAY_DEPTH];
    logic [24:0] dist_reg [DIV_STEPS];

    always_ff @(posedge aclk) begin
        if (en) begin
            pay_reg[0]  <= fr;
            dist_reg[0] <= root_q;
            for (int i = 1; i < PAY_DEPTH; i++) begin
                pay_reg[i] <= pay_reg[i-1];
            end
            for (int i = 1; i < DIV_STEPS; i++) begin
                dist_reg[i] <= dist_reg[i-1];
            end
        end
    end

    // normal magnitudes: |d| << 16 / distance for each axis
    logic [16:0] qx, qy, qz;

    vcc_div u_div_x (
        .aclk (aclk),
        .en   (en),
        .num  (pay_reg[SQ_STEPS-1].mdx),
        .den  (root_q),
        .quo  (qx)
    );

    vcc_div u_div_y (
        .aclk (aclk),
        .en   (en),
        .num  (pay_reg[SQ_STEPS-1].vert),
        .den  (root_q),
        .quo  (qy)
    );

    vcc_div u_div_z (
        .aclk (aclk),
        .en   (en),
        .num  (pay_reg[SQ_STEPS-1].mdz),
        .den  (root_q),
        .quo  (qz)
    );

    // product stage: clamp, coincident-axis override, radius products
    front_t p;
    logic [16:0] mx_c, my_c, mz_c;
    logic        sx_c, sy_c, sz_c;
    logic [40:0] pax_c, pbx_c, pay_c, pby_c, paz_c, pbz_c;

    assign p = pay_reg[PAY_DEPTH-1];

    always_comb begin
        mx_c = (qx > ONE_Q16) ? ONE_Q16 : qx;
        my_c = (qy > ONE_Q16) ? ONE_Q16 : qy;
        mz_c = (qz > ONE_Q16) ? ONE_Q16 : qz;
        sx_c = p.dx_neg;
        sy_c = p.dy_neg;
        sz_c = p.dz_neg;
        if (p.zero) begin
            // coincident axes: straight up or down by the centre heights
            mx_c = '0;
            my_c = ONE_Q16;
            mz_c = '0;
            sy_c = !p.base.cy_ge;
        end
        pax_c = mx_c * p.base.ra;
        pbx_c = mx_c * p.base.rb;
        pay_c = my_c * p.base.ra;
        pby_c = my_c * p.base.rb;
        paz_c = mz_c * p.base.ra;
        pbz_c = mz_c * p.base.rb;
        if (p.zero) begin
            pay_c = '0;
            pby_c = '0;
        end
    end

    logic signed [17:0] nx_reg, ny_reg, nz_reg;
    logic [24:0]        pax_reg, pbx_reg, pay_reg2, pby_reg, paz_reg, pbz_reg;
    logic [24:0]        pen_reg;
    logic               sx_reg, sy_reg, sz_reg, miss_reg;
    base_t              base_reg;
    logic signed [31:0] ya_reg, yb_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            nx_reg   <= sx_c ? -$signed({1'b0, mx_c}) : $signed({1'b0, mx_c});
            ny_reg   <= sy_c ? -$signed({1'b0, my_c}) : $signed({1'b0, my_c});
            nz_reg   <= sz_c ? -$signed({1'b0, mz_c}) : $signed({1'b0, mz_c});
            pax_reg  <= pax_c[40:16];
            pbx_reg  <= pbx_c[40:16];
            pay_reg2 <= pay_c[40:16];
            pby_reg  <= pby_c[40:16];
            paz_reg  <= paz_c[40:16];
            pbz_reg  <= pbz_c[40:16];
            pen_reg  <= p.rs - dist_reg[DIV_STEPS-1];
            sx_reg   <= sx_c;
            sy_reg   <= sy_c;
            sz_reg   <= sz_c;
            miss_reg <= p.miss;
            base_reg <= p.base;
            ya_reg   <= p.ya;
            yb_reg   <= p.yb;
        end
    end

    // output stage: contact point, floor halving, saturation; a miss gives an all-zero item
    function automatic logic signed [31:0] point_of(
        input logic signed [31:0] u,
        input logic signed [31:0] v,
        input logic [24:0]        pa,
        input logic [24:0]        pb,
        input logic               neg
    );
        logic signed [25:0] diff;
        logic signed [25:0] term;
        logic signed [33:0] sum;
        logic signed [32:0] half;
        diff = $signed({1'b0, pb}) - $signed({1'b0, pa});
        term = neg ? -diff : diff;
        sum  = {u[31], u[31], u} + {v[31], v[31], v} + {{8{term[25]}}, term};
        half = sum[33:1];
        if (half[32] != half[31]) begin
            return half[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end
        return half[31:0];
    endfunction

    logic               hit_reg;
    logic signed [17:0] onx_reg, ony_reg, onz_reg;
    logic [24:0]        open_reg;
    logic signed [31:0] opx_reg, opy_reg, opz_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            if (miss_reg) begin
                hit_reg  <= 1'b0;
                onx_reg  <= '0;
                ony_reg  <= '0;
                onz_reg  <= '0;
                open_reg <= '0;
                opx_reg  <= '0;
                opy_reg  <= '0;
                opz_reg  <= '0;
            end else begin
                hit_reg  <= 1'b1;
                onx_reg  <= nx_reg;
                ony_reg  <= ny_reg;
                onz_reg  <= nz_reg;
                open_reg <= pen_reg;
                opx_reg  <= point_of(base_reg.ax, base_reg.bx, pax_reg, pbx_reg, sx_reg);
                opy_reg  <= point_of(ya_reg, yb_reg, pay_reg2, pby_reg, sy_reg);
                opz_reg  <= point_of(base_reg.az, base_reg.bz, paz_reg, pbz_reg, sz_reg);
            end
        end
    end

    assign m_hit         = hit_reg;
    assign m_normal_x    = onx_reg;
    assign m_normal_y    = ony_reg;
    assign m_normal_z    = onz_reg;
    assign m_penetration = open_reg;
    assign m_point_x     = opx_reg;
    assign m_point_y     = opy_reg;
    assign m_point_z     = opz_reg;

endmodule
`default_nettype wire

>>> hw/rtl/vcc_front.sv
`default_nettype none
module vcc_front import vcc_pkg::*; (
    input  wire logic               aclk,
    input  wire logic               en,
    input  wire logic signed [31:0] a_x,
    input  wire logic signed [31:0] a_z,
    input  wire logic signed [31:0] a_y0,
    input  wire logic signed [31:0] a_y1,
    input  wire logic [23:0]        a_radius,
    input  wire logic signed [31:0] a_center_y,
    input  wire logic signed [31:0] b_x,
    input  wire logic signed [31:0] b_z,
    input  wire logic signed [31:0] b_y0,
    input  wire logic signed [31:0] b_y1,
    input  wire logic [23:0]        b_radius,
    input  wire logic signed [31:0] b_center_y,
    output front_t                  fr
);

    // stage 1: order end heights
    base_t              base1_reg, base2_reg, base3_reg;
    logic signed [31:0] ay_lo_reg, ay_hi_reg, by_lo_reg, by_hi_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            base1_reg.ax    <= a_x;
            base1_reg.az    <= a_z;
            base1_reg.bx    <= b_x;
            base1_reg.bz    <= b_z;
            base1_reg.ra    <= a_radius;
            base1_reg.rb    <= b_radius;
            base1_reg.cy_ge <= (a_center_y >= b_center_y);
            ay_lo_reg       <= (a_y0 > a_y1) ? a_y1 : a_y0;
            ay_hi_reg       <= (a_y0 > a_y1) ? a_y0 : a_y1;
            by_lo_reg       <= (b_y0 > b_y1) ? b_y1 : b_y0;
            by_hi_reg       <= (b_y0 > b_y1) ? b_y0 : b_y1;
        end
    end

    // stage 2: deltas, vertical gap, test heights
    logic signed [32:0] dx_c, dz_c, mid_sum_c;
    logic signed [31:0] lo_c, hi_c, ya_c, yb_c;
    logic [32:0]        vert_c;
    logic               dy_neg_c;

    logic [32:0]        mdx2_reg, mdz2_reg, vert2_reg;
    logic [24:0]        rs2_reg;
    logic signed [31:0] ya2_reg, yb2_reg;
    logic               dx_neg2_reg, dz_neg2_reg, dy_neg2_reg;

    always_comb begin
        dx_c      = sx33(base1_reg.ax) - sx33(base1_reg.bx);
        dz_c      = sx33(base1_reg.az) - sx33(base1_reg.bz);
        lo_c      = (ay_lo_reg > by_lo_reg) ? ay_lo_reg : by_lo_reg;
        hi_c      = (ay_hi_reg < by_hi_reg) ? ay_hi_reg : by_hi_reg;
        mid_sum_c = sx33(lo_c) + sx33(hi_c);
        dy_neg_c  = 1'b0;
        if (ay_hi_reg < by_lo_reg) begin
            vert_c   = 33'(sx33(by_lo_reg) - sx33(ay_hi_reg));
            ya_c     = ay_hi_reg;
            yb_c     = by_lo_reg;
            dy_neg_c = 1'b1;
        end else if (by_hi_reg < ay_lo_reg) begin
            vert_c = 33'(sx33(ay_lo_reg) - sx33(by_hi_reg));
            ya_c   = ay_lo_reg;
            yb_c   = by_hi_reg;
        end else begin
            vert_c = '0;
            ya_c   = mid_sum_c[32:1];
            yb_c   = mid_sum_c[32:1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            base2_reg   <= base1_reg;
            mdx2_reg    <= dx_c[32] ? 33'(-dx_c) : 33'(dx_c);
            mdz2_reg    <= dz_c[32] ? 33'(-dz_c) : 33'(dz_c);
            dx_neg2_reg <= dx_c[32];
            dz_neg2_reg <= dz_c[32];
            vert2_reg   <= vert_c;
            dy_neg2_reg <= dy_neg_c;
            ya2_reg     <= ya_c;
            yb2_reg     <= yb_c;
            rs2_reg     <= {1'b0, base1_reg.ra} + {1'b0, base1_reg.rb};
        end
    end

    // stage 3: far test and squares
    logic [49:0]        sqx3_reg, sqz3_reg, sqv3_reg, rs_sq3_reg;
    logic [24:0]        rs3_reg, mdx3_reg, mdz3_reg, vert3_reg;
    logic signed [31:0] ya3_reg, yb3_reg;
    logic               far3_reg, dx_neg3_reg, dz_neg3_reg, dy_neg3_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            base3_reg   <= base2_reg;
            far3_reg    <= (mdx2_reg > {8'd0, rs2_reg}) || (mdz2_reg > {8'd0, rs2_reg})
                           || (vert2_reg > {8'd0, rs2_reg});
            sqx3_reg    <= mdx2_reg[24:0] * mdx2_reg[24:0];
            sqz3_reg    <= mdz2_reg[24:0] * mdz2_reg[24:0];
            sqv3_reg    <= vert2_reg[24:0] * vert2_reg[24:0];
            rs_sq3_reg  <= rs2_reg * rs2_reg;
            rs3_reg     <= rs2_reg;
            mdx3_reg    <= mdx2_reg[24:0];
            mdz3_reg    <= mdz2_reg[24:0];
            vert3_reg   <= vert2_reg[24:0];
            ya3_reg     <= ya2_reg;
            yb3_reg     <= yb2_reg;
            dx_neg3_reg <= dx_neg2_reg;
            dz_neg3_reg <= dz_neg2_reg;
            dy_neg3_reg <= dy_neg2_reg;
        end
    end

    // stage 4: squared distance, miss and zero tests
    logic [51:0] dist_sq_c;
    front_t      fr_reg;

    assign dist_sq_c = {2'b00, sqx3_reg} + {2'b00, sqz3_reg} + {2'b00, sqv3_reg};

    always_ff @(posedge aclk) begin
        if (en) begin
            fr_reg.base    <= base3_reg;
            fr_reg.rs      <= rs3_reg;
            fr_reg.ya      <= ya3_reg;
            fr_reg.yb      <= yb3_reg;
            fr_reg.mdx     <= mdx3_reg;
            fr_reg.mdz     <= mdz3_reg;
            fr_reg.vert    <= vert3_reg;
            fr_reg.dx_neg  <= dx_neg3_reg;
            fr_reg.dz_neg  <= dz_neg3_reg;
            fr_reg.dy_neg  <= dy_neg3_reg;
            fr_reg.miss    <= far3_reg || (dist_sq_c > {2'b00, rs_sq3_reg});
            fr_reg.zero    <= (dist_sq_c == 52'd0);
            fr_reg.dist_sq <= dist_sq_c[49:0];
        end
    end

    assign fr = fr_reg;

endmodule
`default_nettype wire

>>> hw/rtl/vcc_sqrt.sv
`default_nettype none
module vcc_sqrt import vcc_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        en,
    input  wire logic [49:0] value,
    output logic [24:0]      root
);

    logic [25:0] rem_reg  [SQ_STEPS];
    logic [24:0] root_reg [SQ_STEPS];
    logic [49:0] val_reg  [SQ_STEPS];

    // one root bit per stage, restoring
    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
        logic [25:0] rem_in;
        logic [24:0] root_in;
        logic [49:0] val_in;
        logic [27:0] t_c, trial_c, diff_c;
        logic        ge_c;

        if (k == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign val_in  = value;
        end else begin : g_rest
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign val_in  = val_reg[k-1];
        end

        assign t_c     = {rem_in, val_in[49:48]};
        assign trial_c = {1'b0, root_in, 2'b01};
        assign ge_c    = (t_c >= trial_c);
        assign diff_c  = t_c - trial_c;

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k]  <= ge_c ? diff_c[25:0] : t_c[25:0];
                root_reg[k] <= {root_in[23:0], ge_c};
                val_reg[k]  <= {val_in[47:0], 2'b00};
            end
        end
    end

    assign root = root_reg[SQ_STEPS-1];

endmodule
`default_nettype wire

>>> hw/rtl/vcc_div.sv
`default_nettype none
module vcc_div import vcc_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        en,
    input  wire logic [24:0] num,
    input  wire logic [24:0] den,
    output logic [16:0]      quo
);

    // quotient of (num << 16) / den, one bit per stage; num <= den keeps it in 17 bits
    logic [24:0] rem_reg [DIV_STEPS];
    logic [16:0] quo_reg [DIV_STEPS];
    logic [24:0] den_reg [DIV_STEPS];

    for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
        logic [24:0] rem_in, den_in;
        logic [16:0] quo_in;
        logic        nb;
        logic [25:0] r2_c, diff_c;
        logic        ge_c;

        if (j == 0) begin : g_first
            assign rem_in = {1'b0, num[24:1]};
            assign quo_in = '0;
            assign den_in = den;
            assign nb     = num[0];
        end else begin : g_rest
            assign rem_in = rem_reg[j-1];
            assign quo_in = quo_reg[j-1];
            assign den_in = den_reg[j-1];
            assign nb     = 1'b0;
        end

        assign r2_c   = {rem_in, nb};
        assign ge_c   = (r2_c >= {1'b0, den_in});
        assign diff_c = r2_c - {1'b0, den_in};

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[j] <= ge_c ? diff_c[24:0] : r2_c[24:0];
                quo_reg[j] <= {quo_in[15:0], ge_c};
                den_reg[j] <= den_in;
            end
        end
    end

    assign quo = quo_reg[DIV_STEPS-1];

endmodule
`default_nettype wire

>>> hw/rtl/vcc_checker.sv
`default_nettype none
`include "vertical_capsule_contact_defines.svh"
module vcc_checker (
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               s_valid,
    input wire logic               s_ready,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire logic               m_hit,
    input wire logic signed [17:0] m_normal_x,
    input wire logic signed [17:0] m_normal_y,
    input wire logic signed [17:0] m_normal_z,
    input wire logic [24:0]        m_penetration,
    input wire logic signed [31:0] m_point_x,
    input wire logic signed [31:0] m_point_y,
    input wire logic signed [31:0] m_point_z
);

    // held result item stays put (checked on hit, point x and normal y)
    `VCC_ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_hit) && $stable(m_point_x) && $stable(m_normal_y))

    // a miss carries an all-zero item
    `VCC_ASSERT_IMPL(a_miss_zero, aclk, aresetn, m_valid && !m_hit, m_normal_x == 0 && m_normal_y == 0 && m_normal_z == 0 && m_penetration == 0 && m_point_x == 0 && m_point_y == 0 && m_point_z == 0)

    // normal components never exceed unit length
    `VCC_ASSERT_IMPL(a_norm_range, aclk, aresetn, m_valid && m_hit, m_normal_x <= 18'sd65536 && m_normal_x >= -18'sd65536 && m_normal_y <= 18'sd65536 && m_normal_y >= -18'sd65536 && m_normal_z <= 18'sd65536 && m_normal_z >= -18'sd65536)

    // a held output stalls the whole pipe
    `VCC_ASSERT_IMPL(a_stall, aclk, aresetn, m_valid && !m_ready, !s_ready)

endmodule

bind vertical_capsule_contact vcc_checker u_vcc_checker (.*);
`default_nettype wire
